// ===== hdl/pst_pkg.sv =====
// Package for the Phong specular term pipeline: transaction payload types
// and fixed constants. No dependencies.
package pst_pkg;

   localparam int LANE_BITS = 16;
   localparam int LOG_FRAC  = 16;
   localparam int OUT_BITS  = 17;
   localparam int KS_BASE   = 8397;
   localparam int KS_SLOPE  = 10902;
   localparam logic [OUT_BITS-1:0] OUT_MAX = 17'd131071;

   typedef struct packed {
      logic signed [15:0] to_light_x;
      logic signed [15:0] to_light_y;
      logic signed [15:0] to_light_z;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic signed [15:0] view_x;
      logic signed [15:0] view_y;
      logic signed [15:0] view_z;
      logic [47:0]        light_rgb;
      logic [9:0]         shininess;
   } req_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] spec_red;
      logic [OUT_BITS-1:0] spec_green;
      logic [OUT_BITS-1:0] spec_blue;
      logic                spec_valid;
   } rsp_type;

endpackage

// ===== hdl/pst_chain.sv =====
// Power and log2 chain: one exponent bit and one log2 fraction round per stage.
// Depends on pst_pkg.
module pst_chain #(
   parameter int FRAC_BITS = 14,
   parameter int SW        = 10,
   parameter int NW        = 4,
   parameter int SIDE_W    = 49
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             adv,
   input  logic                             in_vld,
   input  logic [FRAC_BITS:0]               in_b,
   input  logic [SW-1:0]                    in_s,
   input  logic [NW-1:0]                    in_n,
   input  logic [pst_pkg::LOG_FRAC:0]       in_m,
   input  logic [SIDE_W-1:0]                in_side,
   output logic                             out_vld,
   output logic [FRAC_BITS:0]               out_p,
   output logic [NW+pst_pkg::LOG_FRAC-1:0]  out_log,
   output logic [SIDE_W-1:0]                out_side
);

   localparam int LF  = pst_pkg::LOG_FRAC;
   localparam int NCH = (SW > LF) ? SW : LF;
   localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

   logic                vld_ff  [NCH];
   logic [FRAC_BITS:0]  p_ff    [NCH];
   logic [FRAC_BITS:0]  b_ff    [NCH];
   logic [SW-1:0]       s_ff    [NCH];
   logic [NW-1:0]       n_ff    [NCH];
   logic [LF:0]         m_ff    [NCH];
   logic [LF-1:0]       frac_ff [NCH];
   logic [SIDE_W-1:0]   side_ff [NCH];

   for (genvar k = 0; k < NCH; k++) begin : g_stage
      logic                  vld_in;
      logic [FRAC_BITS:0]    p_in, b_in, p_prev, b_prev;
      logic [SW-1:0]         s_prev;
      logic [NW-1:0]         n_prev;
      logic [LF:0]           m_in, m_prev;
      logic [LF-1:0]         frac_in, frac_prev;
      logic [SIDE_W-1:0]     side_prev;
      logic [2*FRAC_BITS+1:0] pb, bb;
      logic [2*LF+1:0]       mm;

      if (k == 0) begin : g_first
         assign vld_in    = in_vld;
         assign p_prev    = ONE;
         assign b_prev    = in_b;
         assign s_prev    = in_s;
         assign n_prev    = in_n;
         assign m_prev    = in_m;
         assign frac_prev = '0;
         assign side_prev = in_side;
      end else begin : g_next
         assign vld_in    = vld_ff[k-1];
         assign p_prev    = p_ff[k-1];
         assign b_prev    = b_ff[k-1];
         assign s_prev    = s_ff[k-1];
         assign n_prev    = n_ff[k-1];
         assign m_prev    = m_ff[k-1];
         assign frac_prev = frac_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      always_comb begin
         pb = (2*FRAC_BITS+2)'(p_prev) * (2*FRAC_BITS+2)'(b_prev);
         bb = (2*FRAC_BITS+2)'(b_prev) * (2*FRAC_BITS+2)'(b_prev);
         mm = (2*LF+2)'(m_prev) * (2*LF+2)'(m_prev);
         p_in    = p_prev;
         b_in    = b_prev;
         m_in    = m_prev;
         frac_in = frac_prev;
         if (k < SW) begin
            if (s_prev[k % SW]) begin
               p_in = pb[2*FRAC_BITS:FRAC_BITS];
            end
            b_in = bb[2*FRAC_BITS:FRAC_BITS];
         end
         if (k < LF) begin
            // square the mantissa; renormalize when it reaches two
            if (mm[2*LF+1]) begin
               m_in = mm[2*LF+1:LF+1];
               frac_in[(LF-1-k) % LF] = 1'b1;
            end else begin
               m_in = mm[2*LF:LF];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_in;
         end
         if (adv) begin
            p_ff[k]    <= p_in;
            b_ff[k]    <= b_in;
            s_ff[k]    <= s_prev;
            n_ff[k]    <= n_prev;
            m_ff[k]    <= m_in;
            frac_ff[k] <= frac_in;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_vld  = vld_ff[NCH-1];
   assign out_p    = p_ff[NCH-1];
   assign out_log  = {n_ff[NCH-1], frac_ff[NCH-1]};
   assign out_side = side_ff[NCH-1];

endmodule

// ===== hdl/phong_specular_term.sv =====
// Phong specular term top level: reflection and cosine front end, power/log
// chain, color scaling back end. Depends on pst_pkg and pst_chain.
//
//   channel | ports                        | direction
//   req     | req_valid req_stall req_data | in
//   rsp     | rsp_valid rsp_stall rsp_data | out
//
// One transaction per cycle while the pipeline is not frozen by rsp_stall; the chain
// takes one exponent bit and one log2 round per stage.
// Synchronous active-high reset clears the valid bits of every stage.
// rsp_stall freezes the whole pipeline while rsp_valid is high; req_stall follows it.
module phong_specular_term #(
   parameter int FRAC_BITS     = 14,
   parameter int MAX_SHININESS = 1023,
   parameter int COLOR_BITS    = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pst_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pst_pkg::rsp_type rsp_data
);

   localparam int LF   = pst_pkg::LOG_FRAC;
   localparam int SW   = $clog2(MAX_SHININESS + 1);
   localparam int SXW  = (SW > 10) ? SW : 10;
   localparam int NW   = $clog2(SW);
   localparam int TW   = (((51 - 2*FRAC_BITS) > 16) ? (51 - 2*FRAC_BITS) : 16) + 1;
   localparam int ACW  = TW + 19;
   localparam int AUXW = 48 + SW + NW + LF + 1;
   localparam int SIDE_W = 49;
   localparam int LW   = NW + LF;
   localparam int KW   = NW + 15;
   localparam int PKW  = FRAC_BITS + 1 + KW;
   localparam int RW   = pst_pkg::LANE_BITS + PKW;
   localparam int RSH  = 32 + FRAC_BITS - COLOR_BITS;
   localparam int OB   = pst_pkg::OUT_BITS;
   localparam logic [SXW-1:0] SMAX = SXW'(MAX_SHININESS);
   localparam logic signed [ACW-1:0] ONE_C = ACW'(1) <<< FRAC_BITS;

   logic adv;
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // stage 1: component products, clamp shininess, log2 setup
   logic [SXW-1:0]    s_ext, s_cl;
   logic [SW-1:0]     s_w;
   logic [NW-1:0]     n_w;
   logic [SW+LF-1:0]  m_w;
   logic [AUXW-1:0]   aux_w;

   always_comb begin
      s_ext = SXW'(req_data.shininess);
      s_cl  = (s_ext > SMAX) ? SMAX : s_ext;
      s_w   = s_cl[SW-1:0];
      n_w   = '0;
      for (int i = 0; i < SW; i++) begin
         if (s_w[i]) begin
            n_w = NW'(i);
         end
      end
      m_w   = {s_w, {LF{1'b0}}} >> n_w;
      aux_w = {req_data.light_rgb, s_w, n_w, m_w[LF:0]};
   end

   logic                vld_ff [6];
   logic [AUXW-1:0]     aux_ff [6];
   logic signed [15:0]  l1_ff [3], n1_ff [3], v1_ff [3];
   logic signed [15:0]  l2_ff [3], n2_ff [3], v2_ff [3];
   logic signed [15:0]  l3_ff [3], v3_ff [3], v4_ff [3];
   logic signed [31:0]  ln1_ff [3];
   logic signed [33:0]  d2_ff;
   logic signed [49:0]  dn3_ff [3];
   logic signed [TW-1:0]    t4_ff [3];
   logic signed [TW+15:0]   tv5_ff [3];
   logic                ok6_ff;
   logic [FRAC_BITS:0]  b6_ff;

   logic signed [15:0]  l_w [3], nv_w [3], v_w [3];
   assign l_w  = '{req_data.to_light_x, req_data.to_light_y, req_data.to_light_z};
   assign nv_w = '{req_data.normal_x, req_data.normal_y, req_data.normal_z};
   assign v_w  = '{req_data.view_x, req_data.view_y, req_data.view_z};

   // stage 6 cosine
   logic signed [ACW-1:0] acc_w, c_w;
   logic                  ok_w;
   logic [FRAC_BITS:0]    b_w;
   logic [SW-1:0]         s5_w;

   always_comb begin
      acc_w = ACW'(tv5_ff[0]) + ACW'(tv5_ff[1]) + ACW'(tv5_ff[2]);
      c_w   = (-acc_w) >>> FRAC_BITS;
      s5_w  = aux_ff[4][NW+LF+SW:NW+LF+1];
      ok_w  = !c_w[ACW-1] && (s5_w != '0);
      b_w   = (c_w > ONE_C) ? ONE_C[FRAC_BITS:0] : c_w[FRAC_BITS:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < 6; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
      if (adv) begin
         aux_ff[0] <= aux_w;
         for (int i = 1; i < 6; i++) begin
            aux_ff[i] <= aux_ff[i-1];
         end
         for (int i = 0; i < 3; i++) begin
            l1_ff[i]  <= l_w[i];
            n1_ff[i]  <= nv_w[i];
            v1_ff[i]  <= v_w[i];
            ln1_ff[i] <= l_w[i] * nv_w[i];
            l2_ff[i]  <= l1_ff[i];
            n2_ff[i]  <= n1_ff[i];
            v2_ff[i]  <= v1_ff[i];
            l3_ff[i]  <= l2_ff[i];
            v3_ff[i]  <= v2_ff[i];
            dn3_ff[i] <= 50'(d2_ff) * 50'(n2_ff[i]);
            v4_ff[i]  <= v3_ff[i];
            // floor(2*d*n / 2^2F) - l
            t4_ff[i]  <= TW'(dn3_ff[i] >>> (2*FRAC_BITS - 1)) - TW'(l3_ff[i]);
            tv5_ff[i] <= (TW+16)'(t4_ff[i]) * (TW+16)'(v4_ff[i]);
         end
         d2_ff  <= 34'(ln1_ff[0]) + 34'(ln1_ff[1]) + 34'(ln1_ff[2]);
         ok6_ff <= ok_w;
         b6_ff  <= b_w;
      end
   end

   logic               ch_vld;
   logic [FRAC_BITS:0] ch_p;
   logic [LW-1:0]      ch_log;
   logic [SIDE_W-1:0]  ch_side;

   pst_chain #(
      .FRAC_BITS(FRAC_BITS),
      .SW(SW),
      .NW(NW),
      .SIDE_W(SIDE_W)
   ) u_chain (
      .clock(clock),
      .reset(reset),
      .adv(adv),
      .in_vld(vld_ff[5]),
      .in_b(b6_ff),
      .in_s(aux_ff[5][NW+LF+SW:NW+LF+1]),
      .in_n(aux_ff[5][NW+LF:LF+1]),
      .in_m(aux_ff[5][LF:0]),
      .in_side({ok6_ff, aux_ff[5][AUXW-1:AUXW-48]}),
      .out_vld(ch_vld),
      .out_p(ch_p),
      .out_log(ch_log),
      .out_side(ch_side)
   );

   // back end: ks, p*ks, lane*p*ks, shift and saturate
   logic               e1_vld_ff, e2_vld_ff, e3_vld_ff;
   logic [SIDE_W-1:0]  e1_side_ff, e2_side_ff, e3_side_ff;
   logic [FRAC_BITS:0] e1_p_ff;
   logic [KW-1:0]      e1_ks_ff;
   logic [PKW-1:0]     e2_pk_ff;
   logic [RW-1:0]      e3_r_ff [3];
   logic [LW+13:0]     ks_prod;
   logic [RW-1:0]      sh_w [3];
   logic [OB-1:0]      sat_w [3];

   assign ks_prod = (LW+14)'(ch_log) * (LW+14)'(pst_pkg::KS_SLOPE);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sh_w[i]  = e3_r_ff[i] >> RSH;
         sat_w[i] = (sh_w[i] > RW'(pst_pkg::OUT_MAX)) ? pst_pkg::OUT_MAX : sh_w[i][OB-1:0];
         if (!e3_side_ff[48]) begin
            sat_w[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_vld_ff <= 1'b0;
         e2_vld_ff <= 1'b0;
         e3_vld_ff <= 1'b0;
         rsp_valid <= 1'b0;
      end else if (adv) begin
         e1_vld_ff <= ch_vld;
         e2_vld_ff <= e1_vld_ff;
         e3_vld_ff <= e2_vld_ff;
         rsp_valid <= e3_vld_ff;
      end
      if (adv) begin
         e1_side_ff <= ch_side;
         e1_p_ff    <= ch_p;
         e1_ks_ff   <= KW'(pst_pkg::KS_BASE) + KW'(ks_prod >> LF);
         e2_side_ff <= e1_side_ff;
         e2_pk_ff   <= PKW'(e1_p_ff) * PKW'(e1_ks_ff);
         e3_side_ff <= e2_side_ff;
         for (int i = 0; i < 3; i++) begin
            e3_r_ff[i] <= RW'(e2_side_ff[47-16*i -: 16]) * RW'(e2_pk_ff);
         end
         rsp_data.spec_red   <= sat_w[0];
         rsp_data.spec_green <= sat_w[1];
         rsp_data.spec_blue  <= sat_w[2];
         rsp_data.spec_valid <= e3_side_ff[48];
      end
   end

endmodule

// ===== tb/pst_checker.sv =====
// Checker for the Phong specular term pipeline: watches both channels, predicts
// each result from the accepted request and compares in order. Depends on pst_pkg.
`timescale 1ns / 100ps
module pst_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  pst_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  pst_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending_count
);

   localparam int FRAC = 14;
   localparam int SHINE_MAX = 1023;
   localparam int COLOR = 16;

   pst_pkg::rsp_type expected_rsp_q[$];

   function automatic longint floor_div_pow2(longint x, int sh);
      return x >>> sh;
   endfunction

   function automatic longint unsigned shine_log2(longint unsigned s);
      int n;
      longint unsigned m, frac;
      n = 0;
      frac = 0;
      while ((s >> (n + 1)) != 0) n++;
      m = (s << 16) >> n;
      for (int k = 15; k >= 0; k--) begin
         m = (m * m) >> 16;
         if (m >= (64'd2 << 16)) begin
            m = m >> 1;
            frac |= 64'd1 << k;
         end
      end
      return (longint'(n) << 16) | frac;
   endfunction

   function automatic pst_pkg::rsp_type specular_of(pst_pkg::req_type r);
      pst_pkg::rsp_type o;
      longint l[3], nv[3], v[3], d, acc, c, t;
      longint unsigned s, ks, p, b, one, lane, res;
      l = '{r.to_light_x, r.to_light_y, r.to_light_z};
      nv = '{r.normal_x, r.normal_y, r.normal_z};
      v = '{r.view_x, r.view_y, r.view_z};
      o = '0;
      s = r.shininess;
      if (s > SHINE_MAX) s = SHINE_MAX;
      d = l[0] * nv[0] + l[1] * nv[1] + l[2] * nv[2];
      acc = 0;
      for (int i = 0; i < 3; i++) begin
         t = floor_div_pow2(2 * d * nv[i], 2 * FRAC) - l[i];
         acc += t * v[i];
      end
      c = floor_div_pow2(-acc, FRAC);
      if (c < 0 || s == 0) return o;
      one = 64'd1 << FRAC;
      b = c;
      if (b > one) b = one;
      p = one;
      ks = pst_pkg::KS_BASE + ((shine_log2(s) * pst_pkg::KS_SLOPE) >> 16);
      while (s != 0) begin
         if (s[0]) p = (p * b) >> FRAC;
         b = (b * b) >> FRAC;
         s = s >> 1;
      end
      for (int i = 0; i < 3; i++) begin
         lane = (r.light_rgb >> (32 - 16 * i)) & 64'hFFFF;
         res = (lane * p * ks) >> (32 + FRAC - COLOR);
         if (res > pst_pkg::OUT_MAX) res = pst_pkg::OUT_MAX;
         if (i == 0) o.spec_red = pst_pkg::OUT_BITS'(res);
         else if (i == 1) o.spec_green = pst_pkg::OUT_BITS'(res);
         else o.spec_blue = pst_pkg::OUT_BITS'(res);
      end
      o.spec_valid = 1'b1;
      return o;
   endfunction

   initial begin
      fail_count = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      pst_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) expected_rsp_q.push_back(specular_of(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: unexpected transaction, actual %h", $time, rsp_data);
               fail_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (want !== rsp_data) begin
                  $display({"%0t: mismatch, expected r=%0d g=%0d b=%0d v=%0d,",
                            " actual r=%0d g=%0d b=%0d v=%0d"},
                     $time, want.spec_red, want.spec_green, want.spec_blue,
                     want.spec_valid, rsp_data.spec_red, rsp_data.spec_green,
                     rsp_data.spec_blue, rsp_data.spec_valid);
                  fail_count++;
               end
            end
         end
      end
      pending_count = expected_rsp_q.size();
   end
endmodule

// ===== tb/testbench.sv =====
// Top of the Phong specular term testbench: clock, reset, request stimulus,
// response stall and verdict. Depends on pst_pkg, pst_checker and the block.
`timescale 1ns / 100ps
module testbench;

   localparam int RANDOM_ITEMS = 1800;
   localparam int CYCLE_LIMIT = 400000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   pst_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   pst_pkg::rsp_type rsp_data;
   int               fail_count, pending_count;
   int               cycle_count = 0;
   bit               hold_off = 1'b0;
   bit               calm = 1'b0;

   always #5 clock = ~clock;

   phong_specular_term u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   pst_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   function automatic logic signed [15:0] unit_comp();
      case ($urandom_range(0, 9))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'sd0;
         3: return 16'($urandom);
         default: return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
      endcase
   endfunction

   function automatic pst_pkg::req_type random_item();
      pst_pkg::req_type r;
      int a;
      r.to_light_x = unit_comp();
      r.to_light_y = unit_comp();
      r.to_light_z = unit_comp();
      r.normal_x = unit_comp();
      r.normal_y = unit_comp();
      r.normal_z = unit_comp();
      r.view_x = unit_comp();
      r.view_y = unit_comp();
      r.view_z = unit_comp();
      // mirror geometry: view opposite to the reflection gives cosine near one
      if ($urandom_range(0, 2) == 0) begin
         a = int'($urandom_range(0, 2));
         r.normal_x = (a == 0) ? 16'sd16384 : 16'sd0;
         r.normal_y = (a == 1) ? 16'sd16384 : 16'sd0;
         r.normal_z = (a == 2) ? 16'sd16384 : 16'sd0;
         r.view_x = (a == 0) ? -r.to_light_x : r.to_light_x;
         r.view_y = (a == 1) ? -r.to_light_y : r.to_light_y;
         r.view_z = (a == 2) ? -r.to_light_z : r.to_light_z;
      end
      r.light_rgb = 48'({$urandom, $urandom});
      case ($urandom_range(0, 3))
         0: r.shininess = 10'($urandom_range(0, 8));
         1: r.shininess = 10'($urandom_range(1000, 1023));
         default: r.shininess = 10'($urandom);
      endcase
      return r;
   endfunction

   task automatic send(pst_pkg::req_type r);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      if (!calm && $urandom_range(0, 99) < 20) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
   endtask

   task automatic send_mirror(logic [15:0] lx, logic [47:0] rgb, logic [9:0] sh);
      pst_pkg::req_type r;
      r = '0;
      r.to_light_x = lx;
      r.to_light_z = 16'sd16384;
      r.normal_z = 16'sd16384;
      r.view_x = lx;
      r.view_z = -16'sd16384;
      r.light_rgb = rgb;
      r.shininess = sh;
      send(r);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[phong_specular_term] ERROR");
         $finish;
      end
   end

   // response stall: random, quiet during the calm stretch, solid during hold-off
   always @(posedge clock)
      rsp_stall <= hold_off || (!calm && $urandom_range(0, 99) < 20);

   initial begin
      pst_pkg::req_type r;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_mirror(16'sd0, 48'hFFFF_FFFF_FFFF, 10'd1);
      send_mirror(16'sd0, 48'hFFFF_FFFF_FFFF, 10'd1023);
      send_mirror(16'sd0, 48'hFFFF_0000_8000, 10'd0);
      send_mirror(16'sd4000, 48'h1234_5678_9ABC, 10'd2);
      send_mirror(16'sd0, 48'h0, 10'd512);
      send_mirror(16'sh7FFF, 48'hFFFF_FFFF_FFFF, 10'd3);
      send_mirror(16'sh8000, 48'h8000_8000_8000, 10'd7);
      send_mirror(16'sd16384, 48'hFFFF_FFFF_FFFF, 10'd1);
      r = '0;
      r.to_light_z = 16'sd16384;
      r.normal_z = 16'sd16384;
      r.view_z = 16'sd16384;  // negative cosine
      r.light_rgb = '1;
      r.shininess = 10'd5;
      send(r);
      r = '1;  // every field at all ones: vector components of -1, shininess 1023
      send(r);
      r.view_x = 16'sh7FFF;
      r.view_y = 16'sh7FFF;
      r.view_z = 16'sh7FFF;
      r.to_light_x = 16'sh8000;
      send(r);
      // fill the pipeline against a long receiver hold-off
      hold_off = 1'b1;
      fork
         begin
            repeat (120) @(posedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 60; i++) send(random_item());
      join
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         calm = (i >= 600 && i < 900);
         send(random_item());
      end
      req_valid <= 1'b0;
      calm = 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("[phong_specular_term] OK");
      else
         $display("[phong_specular_term] ERROR");
      $finish;
   end
endmodule
